[rtl/core/lav_pkg.sv]
// shared constants for the look-at view matrix block
package lav_pkg;

  // default word width and fraction bits of the fixed-point format
  localparam int unsigned LAV_DATA_WIDTH = 32;
  localparam int unsigned LAV_FRAC_BITS  = 16;

endpackage

[rtl/core/lav_in_if.sv]
// input channel: eye, target and up hint vectors
interface lav_in_if #(
  parameter int unsigned DATA_WIDTH = lav_pkg::LAV_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] eye_x;
  logic signed [DATA_WIDTH-1:0] eye_y;
  logic signed [DATA_WIDTH-1:0] eye_z;
  logic signed [DATA_WIDTH-1:0] target_x;
  logic signed [DATA_WIDTH-1:0] target_y;
  logic signed [DATA_WIDTH-1:0] target_z;
  logic signed [DATA_WIDTH-1:0] up_x;
  logic signed [DATA_WIDTH-1:0] up_y;
  logic signed [DATA_WIDTH-1:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

[rtl/core/lav_out_if.sv]
// output channel: basis vectors and translation of the view matrix
interface lav_out_if #(
  parameter int unsigned DATA_WIDTH = lav_pkg::LAV_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] right_x;
  logic signed [DATA_WIDTH-1:0] right_y;
  logic signed [DATA_WIDTH-1:0] right_z;
  logic signed [DATA_WIDTH-1:0] upv_x;
  logic signed [DATA_WIDTH-1:0] upv_y;
  logic signed [DATA_WIDTH-1:0] upv_z;
  logic signed [DATA_WIDTH-1:0] fwd_x;
  logic signed [DATA_WIDTH-1:0] fwd_y;
  logic signed [DATA_WIDTH-1:0] fwd_z;
  logic signed [DATA_WIDTH-1:0] trans_x;
  logic signed [DATA_WIDTH-1:0] trans_y;
  logic signed [DATA_WIDTH-1:0] trans_z;

  modport source (
    output valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
           fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
           fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

[rtl/core/look_at_view_matrix.sv]
// look-at view matrix pipeline, top level
// One word is taken every cycle unless the pipeline is held; defaults give Q16.16 words.
// The depth is set by the square root, which settles one root bit per stage over DATA_WIDTH
// stages, and by the three division lanes, which settle one quotient bit per stage over
// FRAC_BITS + 1 stages; the squares and their sum take two stages before the root, the
// forward vector one after the division, and the cross and dot products then take seven
// more stages. The whole pipeline holds when the result is not taken, so a stall loses
// nothing and the next word can still enter while the last stage is empty.
module look_at_view_matrix #(
  parameter int unsigned DATA_WIDTH = lav_pkg::LAV_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = lav_pkg::LAV_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_in_if.sink    in_i,
  lav_out_if.source out_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = 2 * W + 2;
  localparam int unsigned TD  = 3 + W;
  localparam int unsigned TF  = 4 + W + F;
  localparam int unsigned NST = TF + 8;

  localparam logic [W-1:0]   QMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   QMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] QMAXL = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] SGNL  = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef logic [2:0][W-1:0] vec_t;
  typedef struct packed {
    vec_t eye;
    vec_t up;
    vec_t d;
  } side_t;

  // magnitude of a signed word
  function automatic logic [W-1:0] mag_f(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // sign and full magnitude product
  function automatic logic [2*W:0] pmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, mag_f(a)} * {{W{1'b0}}, mag_f(b)};
    return {a[W-1] ^ b[W-1], p};
  endfunction

  // signed word from magnitude, clamped
  function automatic logic [W-1:0] fmag(input logic [2*W-1:0] m, input logic neg);
    if (!neg) begin
      return (m > QMAXL) ? QMAX : m[W-1:0];
    end
    return (m >= SGNL) ? QMIN : (~m[W-1:0] + 1'b1);
  endfunction

  // product shifted down by the fraction bits, clamped
  function automatic logic [W-1:0] qfin(input logic [2*W:0] x);
    logic [2*W-1:0] sh;
    sh = x[2*W-1:0] >> F;
    return fmag(sh, x[2*W]);
  endfunction

  // clamp a widened sum to the word range
  function automatic logic [W-1:0] sat_w(input logic [W+1:0] v);
    if (!v[W+1] && (v[W:W-1] != 2'b00)) begin
      return QMAX;
    end
    if (v[W+1] && (v[W:W-1] != 2'b11)) begin
      return QMIN;
    end
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    return sat_w({{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
  endfunction

  function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
    return sat_w({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b});
  endfunction

  function automatic logic [W-1:0] sneg(input logic [W-1:0] a);
    return ssub('0, a);
  endfunction

  // pipeline advance: everything moves unless the last word is held
  logic            en;
  logic [NST-1:0]  v_q;

  assign en          = !v_q[NST-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = v_q[NST-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_i.valid};
    end
  end

  // side data travelling alongside each word
  side_t side_q [NST];
  side_t side_d;

  always_comb begin
    side_d.eye = {in_i.eye_z, in_i.eye_y, in_i.eye_x};
    side_d.up  = {in_i.up_z, in_i.up_y, in_i.up_x};
    side_d.d   = {ssub(in_i.target_z, in_i.eye_z),
                  ssub(in_i.target_y, in_i.eye_y),
                  ssub(in_i.target_x, in_i.eye_x)};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // squares and squared length
  logic [2:0][2*W-1:0] sqm_q;
  logic [SW-1:0]       rem_q  [W+1];
  logic [W-1:0]        root_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqm_q[i] <= {{W{1'b0}}, mag_f(side_q[0].d[i])} * {{W{1'b0}}, mag_f(side_q[0].d[i])};
      end
      rem_q[0]  <= {2'b00, sqm_q[0]} + {2'b00, sqm_q[1]} + {2'b00, sqm_q[2]};
      root_q[0] <= '0;
    end
  end

  // square root, one bit per stage
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam int unsigned B = W - 1 - k;
    logic [SW-1:0] trial;
    assign trial = ({{(W+2){1'b0}}, root_q[k]} << (B + 1))
                 | ({{(SW-1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial;
          root_q[k+1] <= root_q[k] | ({{(W-1){1'b0}}, 1'b1} << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  // unit division: first quotient bit
  logic [2:0][W-1:0] dr_q [F+1];
  logic [2:0][F:0]   dq_q [F+1];
  logic [W-1:0]      dl_q [F+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= root_q[W];
      for (int i = 0; i < 3; i++) begin
        if (mag_f(side_q[TD-1].d[i]) >= root_q[W]) begin
          dr_q[0][i] <= mag_f(side_q[TD-1].d[i]) - root_q[W];
          dq_q[0][i] <= {{F{1'b0}}, 1'b1};
        end else begin
          dr_q[0][i] <= mag_f(side_q[TD-1].d[i]);
          dq_q[0][i] <= '0;
        end
      end
    end
  end

  // unit division: one fraction bit per stage
  for (genvar j = 1; j <= F; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[j] <= dl_q[j-1];
        for (int i = 0; i < 3; i++) begin
          if ({dr_q[j-1][i], 1'b0} >= {1'b0, dl_q[j-1]}) begin
            dr_q[j][i] <= W'({dr_q[j-1][i], 1'b0} - {1'b0, dl_q[j-1]});
            dq_q[j][i] <= {dq_q[j-1][i][F-1:0], 1'b1};
          end else begin
            dr_q[j][i] <= W'({dr_q[j-1][i], 1'b0});
            dq_q[j][i] <= {dq_q[j-1][i][F-1:0], 1'b0};
          end
        end
      end
    end
  end

  // forward, cross and dot product stages
  vec_t              f_q, f1_q, f2_q, f3_q, f4_q, f5_q, f6_q, f7_q;
  vec_t              r2_q, r3_q, r4_q, r5_q, r6_q, r7_q;
  vec_t              u4_q, u5_q, u6_q, u7_q;
  logic [5:0][2*W:0] pr_q, pu_q;
  logic [2:0][2*W:0] per_q, pef_q, peu_q;
  logic [W-1:0]      sr4_q, sr2_q, sf4_q, sf2_q, su6_q, su2_q;
  logic [W-1:0]      tx5_q, tx6_q, tx7_q, tz5_q, tz6_q, tz7_q, ty7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // normalised forward
      for (int i = 0; i < 3; i++) begin
        if (dl_q[F] == '0) begin
          f_q[i] <= '0;
        end else begin
          f_q[i] <= fmag({{(2*W-F-1){1'b0}}, dq_q[F][i]}, side_q[TF-1].d[i][W-1]);
        end
      end
      // right = up x f
      pr_q[0] <= pmul(side_q[TF].up[1], f_q[2]);
      pr_q[1] <= pmul(side_q[TF].up[2], f_q[1]);
      pr_q[2] <= pmul(side_q[TF].up[2], f_q[0]);
      pr_q[3] <= pmul(side_q[TF].up[0], f_q[2]);
      pr_q[4] <= pmul(side_q[TF].up[0], f_q[1]);
      pr_q[5] <= pmul(side_q[TF].up[1], f_q[0]);
      f1_q    <= f_q;
      for (int i = 0; i < 3; i++) begin
        r2_q[i] <= ssub(qfin(pr_q[2*i]), qfin(pr_q[2*i+1]));
      end
      f2_q <= f1_q;
      // derived up = f x right, and the eye dot products with right and f
      pu_q[0] <= pmul(f2_q[1], r2_q[2]);
      pu_q[1] <= pmul(f2_q[2], r2_q[1]);
      pu_q[2] <= pmul(f2_q[2], r2_q[0]);
      pu_q[3] <= pmul(f2_q[0], r2_q[2]);
      pu_q[4] <= pmul(f2_q[0], r2_q[1]);
      pu_q[5] <= pmul(f2_q[1], r2_q[0]);
      for (int i = 0; i < 3; i++) begin
        per_q[i] <= pmul(side_q[TF+2].eye[i], r2_q[i]);
        pef_q[i] <= pmul(side_q[TF+2].eye[i], f2_q[i]);
      end
      r3_q <= r2_q;
      f3_q <= f2_q;
      for (int i = 0; i < 3; i++) begin
        u4_q[i] <= ssub(qfin(pu_q[2*i]), qfin(pu_q[2*i+1]));
      end
      sr4_q <= sadd(qfin(per_q[0]), qfin(per_q[1]));
      sr2_q <= qfin(per_q[2]);
      sf4_q <= sadd(qfin(pef_q[0]), qfin(pef_q[1]));
      sf2_q <= qfin(pef_q[2]);
      r4_q  <= r3_q;
      f4_q  <= f3_q;
      // eye dot derived up
      for (int i = 0; i < 3; i++) begin
        peu_q[i] <= pmul(side_q[TF+4].eye[i], u4_q[i]);
      end
      tx5_q <= sneg(sadd(sr4_q, sr2_q));
      tz5_q <= sneg(sadd(sf4_q, sf2_q));
      u5_q  <= u4_q;
      r5_q  <= r4_q;
      f5_q  <= f4_q;
      su6_q <= sadd(qfin(peu_q[0]), qfin(peu_q[1]));
      su2_q <= qfin(peu_q[2]);
      tx6_q <= tx5_q;
      tz6_q <= tz5_q;
      u6_q  <= u5_q;
      r6_q  <= r5_q;
      f6_q  <= f5_q;
      // output register
      ty7_q <= sneg(sadd(su6_q, su2_q));
      tx7_q <= tx6_q;
      tz7_q <= tz6_q;
      u7_q  <= u6_q;
      r7_q  <= r6_q;
      f7_q  <= f6_q;
    end
  end

  // result word
  assign out_o.right_x = r7_q[0];
  assign out_o.right_y = r7_q[1];
  assign out_o.right_z = r7_q[2];
  assign out_o.upv_x   = u7_q[0];
  assign out_o.upv_y   = u7_q[1];
  assign out_o.upv_z   = u7_q[2];
  assign out_o.fwd_x   = f7_q[0];
  assign out_o.fwd_y   = f7_q[1];
  assign out_o.fwd_z   = f7_q[2];
  assign out_o.trans_x = tx7_q;
  assign out_o.trans_y = ty7_q;
  assign out_o.trans_z = tz7_q;

endmodule

[tb/testbench.sv]
// self-checking testbench of the look-at view matrix pipeline
`timescale 1ns / 1ps

module testbench;
  import lav_pkg::*;

  localparam int unsigned DW        = LAV_DATA_WIDTH;
  localparam int unsigned FB        = LAV_FRAC_BITS;
  localparam longint      QMAX      = 64'sd2147483647;
  localparam longint      QMIN      = -64'sd2147483648;
  localparam int          N_RANDOM  = 400;
  localparam int          LATENCY   = DW + FB + 11;
  localparam int          IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [DW-1:0] eye_x, eye_y, eye_z;
    logic signed [DW-1:0] target_x, target_y, target_z;
    logic signed [DW-1:0] up_x, up_y, up_z;
  } view_in_t;

  typedef struct packed {
    logic signed [DW-1:0] right_x, right_y, right_z;
    logic signed [DW-1:0] upv_x, upv_y, upv_z;
    logic signed [DW-1:0] fwd_x, fwd_y, fwd_z;
    logic signed [DW-1:0] trans_x, trans_y, trans_z;
  } view_out_t;

  typedef struct {
    view_in_t  stim;
    bit        known;
    view_out_t result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lav_in_if  #(.DATA_WIDTH(DW)) in_if ();
  lav_out_if #(.DATA_WIDTH(DW)) out_if ();

  look_at_view_matrix #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  view_out_t expected_views[$];
  int        n_errors;
  int        n_words_in;
  int        n_words_out;
  int        idle_cycles;
  int        cycle_count;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // saturating fixed-point helpers
  function automatic longint clamp_word(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint signed_from_mag(longint unsigned m, bit neg);
    if (!neg) return (m > longint'(QMAX)) ? QMAX : longint'(m);
    return (m >= 64'd2147483648) ? QMIN : -longint'(m);
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = (abs_of(a) * abs_of(b)) >> FB;
    return signed_from_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_cross(longint a, longint b, longint c, longint d);
    return clamp_word(fx_mul(a, b) - fx_mul(c, d));
  endfunction

  function automatic longint fx_neg_dot(longint e0, longint e1, longint e2,
                                        longint v0, longint v1, longint v2);
    longint s;
    s = clamp_word(fx_mul(e0, v0) + fx_mul(e1, v1));
    s = clamp_word(s + fx_mul(e2, v2));
    return clamp_word(-s);
  endfunction

  // floor of the square root of the wide squared length
  function automatic longint unsigned length_floor(logic [127:0] s);
    logic [63:0]  root;
    logic [63:0]  c;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = root | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= s) root = c;
    end
    return root;
  endfunction

  // view matrix entries for one word
  function automatic view_out_t view_matrix(view_in_t v);
    longint         eye[3], d[3], up[3], f[3], r[3], u[3];
    logic [127:0]   sq_len;
    longint unsigned len;
    view_out_t      o;
    eye[0] = longint'(v.eye_x);  eye[1] = longint'(v.eye_y);  eye[2] = longint'(v.eye_z);
    up[0]  = longint'(v.up_x);   up[1]  = longint'(v.up_y);   up[2]  = longint'(v.up_z);
    d[0]   = clamp_word(longint'(v.target_x) - eye[0]);
    d[1]   = clamp_word(longint'(v.target_y) - eye[1]);
    d[2]   = clamp_word(longint'(v.target_z) - eye[2]);
    sq_len = '0;
    for (int i = 0; i < 3; i++)
      sq_len += {64'd0, abs_of(d[i])} * {64'd0, abs_of(d[i])};
    len = length_floor(sq_len);
    for (int i = 0; i < 3; i++)
      f[i] = (len == 0) ? 0 : signed_from_mag((abs_of(d[i]) << FB) / len, d[i] < 0);
    r[0] = fx_cross(up[1], f[2], up[2], f[1]);
    r[1] = fx_cross(up[2], f[0], up[0], f[2]);
    r[2] = fx_cross(up[0], f[1], up[1], f[0]);
    u[0] = fx_cross(f[1], r[2], f[2], r[1]);
    u[1] = fx_cross(f[2], r[0], f[0], r[2]);
    u[2] = fx_cross(f[0], r[1], f[1], r[0]);
    o.right_x = DW'(r[0]); o.right_y = DW'(r[1]); o.right_z = DW'(r[2]);
    o.upv_x   = DW'(u[0]); o.upv_y   = DW'(u[1]); o.upv_z   = DW'(u[2]);
    o.fwd_x   = DW'(f[0]); o.fwd_y   = DW'(f[1]); o.fwd_z   = DW'(f[2]);
    o.trans_x = DW'(fx_neg_dot(eye[0], eye[1], eye[2], r[0], r[1], r[2]));
    o.trans_y = DW'(fx_neg_dot(eye[0], eye[1], eye[2], u[0], u[1], u[2]));
    o.trans_z = DW'(fx_neg_dot(eye[0], eye[1], eye[2], f[0], f[1], f[2]));
    return o;
  endfunction

  function automatic view_in_t make_view(int ex, int ey, int ez, int tx, int ty, int tz,
                                         int ux, int uy, int uz);
    view_in_t v;
    v.eye_x = ex; v.eye_y = ey; v.eye_z = ez;
    v.target_x = tx; v.target_y = ty; v.target_z = tz;
    v.up_x = ux; v.up_y = uy; v.up_z = uz;
    return v;
  endfunction

  // one coordinate: 0 moderate, 1 full range, 2 extreme values
  function automatic int rand_coord(int kind);
    int pick;
    case (kind)
      0: return int'($urandom_range(0, 2097151)) - 1048576;
      1: return int'($urandom);
      default: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic view_in_t random_view();
    view_in_t v;
    int       cat;
    int       kind;
    cat  = $urandom_range(0, 99);
    kind = (cat < 70) ? 0 : (cat < 88) ? 1 : 2;
    v = make_view(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                  rand_coord(kind), rand_coord(kind), rand_coord(kind),
                  rand_coord(kind), rand_coord(kind), rand_coord(kind));
    // occasional zero-length forward
    if ($urandom_range(0, 99) < 8) begin
      v.target_x = v.eye_x; v.target_y = v.eye_y; v.target_z = v.eye_z;
    end
    return v;
  endfunction

  task automatic check_field(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      n_errors++;
    end
  endtask

  // send one word and wait for its handshake
  task automatic send_view(view_in_t v, int gap);
    @(negedge clk_i);
    in_if.eye_x <= v.eye_x; in_if.eye_y <= v.eye_y; in_if.eye_z <= v.eye_z;
    in_if.target_x <= v.target_x; in_if.target_y <= v.target_y;
    in_if.target_z <= v.target_z;
    in_if.up_x <= v.up_x; in_if.up_y <= v.up_y; in_if.up_z <= v.up_z;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // receiver stall pattern, rotating among four modes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      case ((cycle_count / 97) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ((cycle_count % 7) < 5);
      endcase
    end
  end

  // predict on accepted inputs, check accepted outputs, watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_views.push_back(view_matrix({in_if.eye_x, in_if.eye_y, in_if.eye_z,
        in_if.target_x, in_if.target_y, in_if.target_z,
        in_if.up_x, in_if.up_y, in_if.up_z}));
      n_words_in++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_words_out++;
      if (expected_views.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        view_out_t e;
        e = expected_views.pop_front();
        check_field("right_x", e.right_x, out_if.right_x);
        check_field("right_y", e.right_y, out_if.right_y);
        check_field("right_z", e.right_z, out_if.right_z);
        check_field("upv_x", e.upv_x, out_if.upv_x);
        check_field("upv_y", e.upv_y, out_if.upv_y);
        check_field("upv_z", e.upv_z, out_if.upv_z);
        check_field("fwd_x", e.fwd_x, out_if.fwd_x);
        check_field("fwd_y", e.fwd_y, out_if.fwd_y);
        check_field("fwd_z", e.fwd_z, out_if.fwd_z);
        check_field("trans_x", e.trans_x, out_if.trans_x);
        check_field("trans_y", e.trans_y, out_if.trans_y);
        check_field("trans_z", e.trans_z, out_if.trans_z);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    view_out_t zero_view;
    int        burst;
    int        gap;

    n_errors = 0; n_words_in = 0; n_words_out = 0; idle_cycles = 0; cycle_count = 0;
    in_if.valid = 1'b0;
    in_if.eye_x = '0; in_if.eye_y = '0; in_if.eye_z = '0;
    in_if.target_x = '0; in_if.target_y = '0; in_if.target_z = '0;
    in_if.up_x = '0; in_if.up_y = '0; in_if.up_z = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows; the obvious ones carry their result
    zero_view = '0;
    row.known = 1'b1; row.result = zero_view;
    row.stim = make_view(0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    // zero-length forward with extreme eye and up
    row.stim = make_view(32'h7fffffff, 32'h80000000, 7, 32'h7fffffff, 32'h80000000, 7,
                         32'h7fffffff, 32'h7fffffff, 32'h80000000);
    rows.push_back(row);
    // plain camera on the z axis looking at the origin
    row.stim = make_view(0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0);
    row.result = zero_view;
    row.result.right_x = -(1 << 16);
    row.result.upv_y   = 1 << 16;
    row.result.fwd_z   = -(1 << 16);
    row.result.trans_z = 5 << 16;
    rows.push_back(row);
    row.known = 1'b0;
    row.stim = make_view(0, 0, 0, 1 << 16, 0, 0, 0, 0, 1 << 16); rows.push_back(row);
    row.stim = make_view(0, 0, 0, 0, -(3 << 16), 0, 1 << 16, 0, 0); rows.push_back(row);
    row.stim = make_view(1, 2, 3, 4, 5, 6, 7, 8, 9); rows.push_back(row);
    // difference saturates both ways
    row.stim = make_view(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff); rows.push_back(row);
    row.stim = make_view(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000); rows.push_back(row);
    row.stim = make_view(32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff, 0,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff); rows.push_back(row);
    row.stim = make_view(-1, -1, -1, 1, 1, 1, -1, 1, -1); rows.push_back(row);
    row.stim = make_view(32'hffffffff, 0, 0, 0, 0, 0, 32'h80000000, 0, 0); rows.push_back(row);
    row.stim = make_view(10 << 16, -(20 << 16), 30 << 16, -(5 << 16), 7 << 16, 2 << 16,
                         0, 1 << 16, 0); rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        if (view_matrix(rows[i].stim) != rows[i].result) begin
          $error("directed row %0d: typed result disagrees with prediction", i);
          n_errors++;
        end
      end
      send_view(rows[i].stim, i % 3);
    end

    // random words in bursts with gaps
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) burst = $urandom_range(1, 24);
      burst--;
      gap = (burst == 0 && (n / 100) % 2 == 0) ? $urandom_range(1, 8) : 0;
      send_view(random_view(), gap);
      // drain the pipeline once in the middle of the run
      if (n == N_RANDOM / 2) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("tb: %0d words sent, %0d results checked, directed extremes and zero-length",
             n_words_in, n_words_out);
    $display("tb: forward cases included, under random source gaps and sink stalls");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
